// ===== rtl/core/edf_bucket_selector_warp_starvation_macros.svh =====
// Assertion macros for the EDF bucket selector.
// Used by the top level only.
`ifndef EDF_BUCKET_SELECTOR_WARP_STARVATION_MACROS_SVH
`define EDF_BUCKET_SELECTOR_WARP_STARVATION_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define EBS_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define EBS_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/ebs_pkg.sv =====
// Package for the EDF bucket selector: op codes, reasons, FSM states,
// control struct and per-bucket constant tables. No dependencies.
package ebs_pkg;

  localparam logic [1:0] OP_RUN = 2'd0;
  localparam logic [1:0] OP_EMPTY = 2'd1;
  localparam logic [1:0] OP_SEL = 2'd2;

  localparam logic [1:0] WHY_EDF = 2'd0;
  localparam logic [1:0] WHY_STARVE = 2'd1;
  localparam logic [1:0] WHY_WARP = 2'd2;

  localparam int unsigned WARP_BITS = 13;
  localparam logic [12:0] WARP_MAX = 13'd8191;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the input beat
    logic upd;     // apply runnable / empty op
    logic scan;    // register earliest-deadline pick
    logic eval;    // one decision round
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic settled;  // decision round finished the select
  } sts_t;

  function automatic logic [17:0] lat_of(input logic [2:0] b);
    case (b)
      3'd0: lat_of = 18'd0;
      3'd1: lat_of = 18'd37500;
      3'd2: lat_of = 18'd75000;
      3'd3: lat_of = 18'd150000;
      default: lat_of = 18'd250000;
    endcase
  endfunction

  function automatic logic [12:0] warp_of(input logic [2:0] b);
    case (b)
      3'd0: warp_of = 13'd8000;
      3'd1: warp_of = 13'd4000;
      3'd2: warp_of = 13'd2000;
      3'd3: warp_of = 13'd1000;
      default: warp_of = 13'd0;
    endcase
  endfunction

  function automatic logic [13:0] quant_of(input logic [2:0] b);
    case (b)
      3'd0: quant_of = 14'd10000;
      3'd1: quant_of = 14'd8000;
      3'd2: quant_of = 14'd6000;
      3'd3: quant_of = 14'd4000;
      default: quant_of = 14'd2000;
    endcase
  endfunction

endpackage

// ===== rtl/core/ebs_ctrl.sv =====
// Controller FSM for the EDF bucket selector.
// Depends on ebs_pkg.
module ebs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    op,
  input  ebs_pkg::sts_t sts,
  output ebs_pkg::ctl_t ctl,
  output logic          busy,
  output logic          done
);

  ebs_pkg::state_t state, state_next;
  logic            is_sel, is_sel_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ebs_pkg::ST_IDLE;
      is_sel <= 1'b0;
    end else begin
      state <= state_next;
      is_sel <= is_sel_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    is_sel_next = is_sel;
    ctl = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ebs_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load = 1'b1;
          is_sel_next = (op == ebs_pkg::OP_SEL);
          state_next = (op == ebs_pkg::OP_SEL) ? ebs_pkg::ST_SCAN : ebs_pkg::ST_EVAL;
        end
      end
      ebs_pkg::ST_SCAN: begin
        ctl.scan = 1'b1;
        state_next = ebs_pkg::ST_EVAL;
      end
      ebs_pkg::ST_EVAL: begin
        if (is_sel) begin
          ctl.eval = 1'b1;
          state_next = sts.settled ? ebs_pkg::ST_DONE : ebs_pkg::ST_SCAN;
        end else begin
          ctl.upd = 1'b1;
          state_next = ebs_pkg::ST_DONE;
        end
      end
      ebs_pkg::ST_DONE: begin
        done = 1'b1;
        state_next = ebs_pkg::ST_IDLE;
      end
      default: state_next = ebs_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/ebs_dp.sv =====
// Datapath for the EDF bucket selector: bucket state, EDF scan, decision.
// Depends on ebs_pkg.
module ebs_dp #(
  parameter int BUCKETS   = 5,
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ebs_pkg::ctl_t        ctl,
  input  logic [1:0]           op,
  input  logic [2:0]           bucket,
  input  logic [TIME_BITS-1:0] now_us,
  output ebs_pkg::sts_t        sts,
  output logic                 found,
  output logic [2:0]           chosen,
  output logic [1:0]           why,
  output logic                 error
);

  localparam int DW = TIME_BITS + 1;
  localparam int IW = $clog2(2 * BUCKETS + 3);
  localparam int BW = $clog2(BUCKETS);

  // Captured beat
  logic [1:0]           op_q;
  logic [2:0]           bk_q;
  logic [TIME_BITS-1:0] now_q;

  // Bucket state
  logic [BUCKETS-1:0]   run_m, stv_m, wok_m, wev_m;
  logic [DW-1:0]        dl [BUCKETS];
  logic [TIME_BITS-1:0] ss [BUCKETS];
  logic [12:0]          wl [BUCKETS];
  logic [DW-1:0]        we [BUCKETS];

  // Scan result and round counter
  logic          edf_v;
  logic [BW-1:0] edf;
  logic [IW-1:0] iter;

  // Combinational earliest-deadline pick
  logic          c_v;
  logic [BW-1:0] c_b;
  logic [DW-1:0] c_best;
  always_comb begin
    c_v = 1'b0;
    c_b = '0;
    c_best = '0;
    for (int i = 0; i < BUCKETS; i++) begin
      if (run_m[i] && (!c_v || dl[i] < c_best)) begin
        c_v = 1'b1;
        c_b = BW'(i);
        c_best = dl[i];
      end
    end
  end

  // Lowest set bit finders
  logic          hi_v, wb_v;
  logic [BW-1:0] hi, wb;
  always_comb begin
    hi_v = 1'b0; hi = '0; wb_v = 1'b0; wb = '0;
    for (int i = BUCKETS - 1; i >= 0; i--) begin
      if (run_m[i]) begin hi_v = 1'b1; hi = BW'(i); end
      if (wok_m[i]) begin wb_v = 1'b1; wb = BW'(i); end
    end
  end

  // Per-round values
  logic [2:0]           e3, w3, bk3;
  logic [TIME_BITS:0]   stv_end;
  logic [DW-1:0]        now_ext;
  logic [DW-1:0]        dl_e, dl_w, we_w;
  logic                 bk_ok;
  assign e3 = 3'(edf);
  assign w3 = 3'(wb);
  assign bk3 = bk_q;
  assign bk_ok = ({1'b0, bk_q} < 4'(BUCKETS));
  assign now_ext = {1'b0, now_q};
  assign stv_end = {1'b0, ss[edf]} + (TIME_BITS+1)'(ebs_pkg::quant_of(e3));
  assign dl_e = now_ext + DW'(ebs_pkg::lat_of(e3));
  assign dl_w = now_ext + DW'(ebs_pkg::lat_of(w3));
  assign we_w = now_ext + DW'(wl[wb]);

  // Remaining warp at empty
  logic [DW-1:0] wdiff;
  logic [12:0]   wsat;
  assign wdiff = we[bk_q[BW-1:0]] - now_ext;
  assign wsat = (we[bk_q[BW-1:0]] > now_ext)
                ? ((wdiff > DW'(ebs_pkg::WARP_MAX)) ? ebs_pkg::WARP_MAX : wdiff[12:0])
                : 13'd0;

  assign sts.settled = !edf_v || (iter == IW'(2 * BUCKETS + 1)) ||
    !((stv_m[edf] && ({1'b0, now_q} >= stv_end)) ||
      (wb_v && wb < edf && wev_m[wb] && !(we[wb] > now_ext)));

  always_ff @(posedge clk) begin
    if (rst) begin
      run_m <= '0; stv_m <= '0; wok_m <= '0; wev_m <= '0;
      found <= 1'b0; chosen <= '0; why <= '0; error <= 1'b0;
      edf_v <= 1'b0; edf <= '0; iter <= '0;
      for (int i = 0; i < BUCKETS; i++) begin
        dl[i] <= '0; ss[i] <= '0; we[i] <= '0;
        wl[i] <= ebs_pkg::warp_of(3'(i));
      end
    end else begin
      // Beat capture clears the result
      if (ctl.load) begin
        op_q <= op; bk_q <= bucket; now_q <= now_us;
        found <= 1'b0; chosen <= '0; why <= '0; error <= 1'b0;
        iter <= '0;
      end
      if (ctl.scan) begin
        edf_v <= c_v;
        edf <= c_b;
      end
      // Runnable / empty update
      if (ctl.upd) begin
        if (op_q == ebs_pkg::OP_RUN || op_q == ebs_pkg::OP_EMPTY) begin
          if (!bk_ok) begin
            error <= 1'b1;
          end else if (op_q == ebs_pkg::OP_RUN) begin
            if (run_m[bk_q[BW-1:0]]) begin
              error <= 1'b1;
            end else begin
              run_m[bk_q[BW-1:0]] <= 1'b1;
              if (!stv_m[bk_q[BW-1:0]])
                dl[bk_q[BW-1:0]] <= now_ext + DW'(ebs_pkg::lat_of(bk3));
              if (wl[bk_q[BW-1:0]] != 13'd0) wok_m[bk_q[BW-1:0]] <= 1'b1;
            end
          end else begin
            if (!run_m[bk_q[BW-1:0]]) begin
              error <= 1'b1;
            end else begin
              run_m[bk_q[BW-1:0]] <= 1'b0;
              wok_m[bk_q[BW-1:0]] <= 1'b0;
              if (wev_m[bk_q[BW-1:0]]) wl[bk_q[BW-1:0]] <= wsat;
            end
          end
        end
      end
      // One decision round of select
      if (ctl.eval) begin
        iter <= iter + IW'(1);
        if (edf_v) begin
          if (stv_m[edf] && ({1'b0, now_q} >= stv_end)) begin
            stv_m[edf] <= 1'b0;
            ss[edf] <= '0;
            dl[edf] <= dl_e;
          end else if (!wb_v || wb >= edf) begin
            found <= 1'b1;
            chosen <= e3;
            if (!stv_m[edf]) begin
              if (hi < edf && hi_v) begin
                stv_m[edf] <= 1'b1;
                ss[edf] <= now_q;
                why <= ebs_pkg::WHY_STARVE;
              end else begin
                dl[edf] <= dl_e;
                wl[edf] <= ebs_pkg::warp_of(e3);
                wev_m[edf] <= 1'b0;
                we[edf] <= '0;
                if (ebs_pkg::warp_of(e3) != 13'd0) wok_m[edf] <= 1'b1;
                why <= ebs_pkg::WHY_EDF;
              end
            end else begin
              why <= ebs_pkg::WHY_STARVE;
            end
          end else if (!wev_m[wb]) begin
            we[wb] <= we_w;
            wev_m[wb] <= 1'b1;
            dl[wb] <= dl_w;
            found <= 1'b1; chosen <= w3; why <= ebs_pkg::WHY_WARP;
          end else if (we[wb] > now_ext) begin
            dl[wb] <= dl_w;
            found <= 1'b1; chosen <= w3; why <= ebs_pkg::WHY_WARP;
          end else begin
            wl[wb] <= '0;
            wok_m[wb] <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/edf_bucket_selector_warp_starvation.sv =====
// Top level of the EDF root-bucket selector with warp and starvation.
// Depends on ebs_pkg, ebs_ctrl, ebs_dp and the assertion macro header.
//
// Usage: drive op, bucket and now_us with start high while busy is low;
// that edge accepts the beat. Runnable and empty ops pass through EVAL and DONE:
// the result (error set on a conflicting op or bad bucket) appears on
// found/chosen/why/error with done high for exactly one cycle.
// A select runs scan/decide rounds (SCAN then EVAL), at most 2*BUCKETS+2
// rounds, until the choice settles. The shared EDF compare over all
// buckets is registered in SCAN and the decision logic acts in EVAL;
// one beat is in flight at a time.
// done marks the result cycle; the receiver cannot stall and takes it
// then. An unused op code yields an all-zero result.
// Synchronous reset clears all masks, deadlines and warp ends and loads
// the per-bucket warp budgets; the block is ready the cycle after reset.
`include "edf_bucket_selector_warp_starvation_macros.svh"
module edf_bucket_selector_warp_starvation #(
  parameter int BUCKETS   = 5,
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           op,
  input  logic [2:0]           bucket,
  input  logic [TIME_BITS-1:0] now_us,
  output logic                 done,
  output logic                 found,
  output logic [2:0]           chosen,
  output logic [1:0]           why,
  output logic                 error
);

  ebs_pkg::ctl_t ctl;
  ebs_pkg::sts_t sts;

  ebs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(op), .sts(sts),
    .ctl(ctl), .busy(busy), .done(done)
  );

  ebs_dp #(.BUCKETS(BUCKETS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .op(op), .bucket(bucket),
    .now_us(now_us), .sts(sts), .found(found), .chosen(chosen),
    .why(why), .error(error)
  );

  // Checks
  `EBS_ASSERT_IMP(a_found_no_err, clk, rst, done && found, !error)
  `EBS_ASSERT_IMP(a_chosen_range, clk, rst, done && found, {1'b0, chosen} < 4'(BUCKETS))
  `EBS_ASSERT_NXT(a_idle_after_done, clk, rst, done, !busy)

endmodule
